// ----- src/pn3d_pkg.sv -----
// shared types, constants, and the gradient and lerp functions of the 3d noise evaluator
package pn3d_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int TABLE_AW   = 8;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    localparam logic REG_HEIGHT_SCALE = 1'b0;

    localparam logic [11:0] HEIGHT_SCALE_RST = 12'd255;

    typedef logic signed [17:0] off_t;
    typedef logic signed [18:0] grad_t;
    typedef logic signed [19:0] lerp_t;
    typedef logic signed [39:0] prod_t;
    typedef logic        [16:0] fade_t;

    function automatic grad_t grad_q16(input logic [3:0] h, input off_t x, input off_t y,
                                       input off_t z);
        grad_t u;
        grad_t v;
        u = (h < 4'd8) ? grad_t'(x) : grad_t'(y);
        if (h < 4'd4) begin
            v = grad_t'(y);
        end else if (h == 4'd12 || h == 4'd14) begin
            v = grad_t'(x);
        end else begin
            v = grad_t'(z);
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic lerp_t lerp_fin(input lerp_t a, input prod_t p);
        prod_t q;
        q = (p + 40'sd32768) >>> 16;
        return a + lerp_t'(q);
    endfunction

endpackage

// ----- src/perlin_noise_3d_eval_unit.sv -----
// top level of the pipelined improved 3d perlin noise evaluator
//
//  channel   dir  beat contents
//  s_        in   tuser: mode; tdata: table_index, table_value, coord_x, coord_y, coord_z
//  m_        out  tdata: noise_value, scaled_height
//  apb       in   height_scale at byte address 0
//
// one evaluate beat per cycle unless a stalled output holds the pipeline back
// the permutation table is copied into seven rams read in three levels of hashing
// a load beat waits while an evaluate beat sits in the first two stages
// reset clears control state only; the table is not cleared and must be loaded first
// a stalled output holds the pipeline back stage by stage, bubbles are squeezed out
module perlin_noise_3d_eval_unit
    import pn3d_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // table_index, table_value, coord_x, coord_y, coord_z
    input  logic        s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // noise_value, scaled_height, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NSTG = 12;

    logic [11:0] scale_reg;
    logic [NSTG:1]   vld_reg;
    logic [NSTG+1:1] rdy;
    logic [NSTG:1]   adv;
    logic s_acc, acc_eval, acc_load;

    logic [23:0] crd   [3];
    logic [7:0]  ipart [3];
    logic [15:0] frac  [3];

    // stage registers
    logic [7:0]  s1_yi_reg, s1_zi_reg, s2_zi_reg;
    logic [15:0] s1_t_reg [3];
    logic [31:0] s1_sq_reg [3];
    logic [15:0] s2_t_reg [3];
    logic [31:0] s2_t2t_reg [3];
    logic [19:0] s2_poly_reg [3];
    logic [15:0] s3_t_reg [3];
    logic [35:0] s3_fp_reg [3];
    lerp_t       s4_g_reg [8];
    fade_t       s4_f_reg [3];
    lerp_t       s5_a_reg [4];
    prod_t       s5_p_reg [4];
    fade_t       s5_v_reg, s5_w_reg, s6_v_reg, s6_w_reg, s7_w_reg, s8_w_reg;
    lerp_t       s6_l_reg [4];
    lerp_t       s7_a_reg [2];
    prod_t       s7_p_reg [2];
    lerp_t       s8_l_reg [2];
    lerp_t       s9_a_reg;
    prod_t       s9_p_reg;
    lerp_t       s10_n_reg;
    logic [16:0] s11_nv_reg;
    logic [28:0] s11_prod_reg;
    logic [16:0] out_nv_reg;
    logic [11:0] out_sh_reg;

    // next values
    logic [31:0] s1_sq_next [3];
    logic [31:0] s2_t2t_next [3];
    logic [19:0] s2_poly_next [3];
    logic [35:0] s3_fp_next [3];
    lerp_t       s4_g_next [8];
    fade_t       s4_f_next [3];
    lerp_t       s5_a_next [4];
    prod_t       s5_p_next [4];
    lerp_t       s6_l_next [4];
    lerp_t       s7_a_next [2];
    prod_t       s7_p_next [2];
    lerp_t       s8_l_next [2];
    prod_t       s9_p_next;
    lerp_t       s10_n_next;
    logic [16:0] s11_nv_next;
    logic [28:0] s11_prod_next;
    logic [11:0] out_sh_next;

    // ram wiring
    logic [7:0] r1_a, r1_b, r2_a0, r2_a1, r2_b0, r2_b1;
    logic [7:0] h1_a, h1_b, h2_aa, h2_ab, h2_ba, h2_bb;
    logic [7:0] h3 [8];

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT_SCALE) ? {20'd0, scale_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= HEIGHT_SCALE_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_HEIGHT_SCALE) begin
            scale_reg <= pwdata[11:0];
        end
    end

    // handshake and stage flow
    always_comb begin
        rdy[NSTG+1] = m_tready;
        for (int k = NSTG; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = (s_tuser == MODE_LOAD) ? !(vld_reg[1] || vld_reg[2]) : rdy[1];
    assign s_acc    = s_tvalid && s_tready;
    assign acc_eval = s_acc && (s_tuser == MODE_EVAL);
    assign acc_load = s_acc && (s_tuser == MODE_LOAD);

    always_comb begin
        adv[1] = acc_eval;
        for (int k = 2; k <= NSTG; k++) begin
            adv[k] = vld_reg[k-1] && rdy[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= 1'b1;
                end else if (vld_reg[k] && rdy[k+1]) begin
                    vld_reg[k] <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = vld_reg[NSTG];
    assign m_tdata  = {3'd0, out_sh_reg, out_nv_reg};

    // input unpacking
    assign crd[0] = s_tdata[39:16];
    assign crd[1] = s_tdata[63:40];
    assign crd[2] = s_tdata[87:64];

    for (genvar ax = 0; ax < 3; ax++) begin : g_axis
        assign ipart[ax] = 8'(crd[ax] >> FRAC_BITS);
        if (FRAC_BITS >= 16) begin : g_trunc
            assign frac[ax] = 16'(crd[ax][FRAC_BITS-1:0] >> (FRAC_BITS - 16));
        end else begin : g_pad
            assign frac[ax] = {crd[ax][FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
        end
    end

    // permutation table copies
    assign h1_a  = ipart[0];
    assign h1_b  = ipart[0] + 8'd1;
    assign h2_aa = r1_a + s1_yi_reg;
    assign h2_ba = r1_b + s1_yi_reg;
    assign h2_ab = r2_a0 + s2_zi_reg;
    assign h2_bb = r2_a1 + s2_zi_reg;

    pn3d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_x (
        .clk(aclk), .we(acc_load), .waddr(s_tdata[7:0]), .wdata(s_tdata[15:8]),
        .re(adv[1]), .raddr_a(h1_a), .raddr_b(h1_b), .rdata_a(r1_a), .rdata_b(r1_b)
    );

    pn3d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_ya (
        .clk(aclk), .we(acc_load), .waddr(s_tdata[7:0]), .wdata(s_tdata[15:8]),
        .re(adv[2]), .raddr_a(h2_aa), .raddr_b(h2_aa + 8'd1), .rdata_a(r2_a0),
        .rdata_b(r2_a1)
    );

    pn3d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_yb (
        .clk(aclk), .we(acc_load), .waddr(s_tdata[7:0]), .wdata(s_tdata[15:8]),
        .re(adv[2]), .raddr_a(h2_ba), .raddr_b(h2_ba + 8'd1), .rdata_a(r2_b0),
        .rdata_b(r2_b1)
    );

    logic [7:0] h3_ba, h3_bb;
    assign h3_ba = r2_b0 + s2_zi_reg;
    assign h3_bb = r2_b1 + s2_zi_reg;

    pn3d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_z0 (
        .clk(aclk), .we(acc_load), .waddr(s_tdata[7:0]), .wdata(s_tdata[15:8]),
        .re(adv[3]), .raddr_a(h2_ab), .raddr_b(h2_ab + 8'd1), .rdata_a(h3[0]),
        .rdata_b(h3[4])
    );

    pn3d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_z1 (
        .clk(aclk), .we(acc_load), .waddr(s_tdata[7:0]), .wdata(s_tdata[15:8]),
        .re(adv[3]), .raddr_a(h3_ba), .raddr_b(h3_ba + 8'd1), .rdata_a(h3[1]),
        .rdata_b(h3[5])
    );

    pn3d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_z2 (
        .clk(aclk), .we(acc_load), .waddr(s_tdata[7:0]), .wdata(s_tdata[15:8]),
        .re(adv[3]), .raddr_a(h2_bb), .raddr_b(h2_bb + 8'd1), .rdata_a(h3[2]),
        .rdata_b(h3[6])
    );

    pn3d_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_z3 (
        .clk(aclk), .we(acc_load), .waddr(s_tdata[7:0]), .wdata(s_tdata[15:8]),
        .re(adv[3]), .raddr_a(h3_bb), .raddr_b(h3_bb + 8'd1), .rdata_a(h3[3]),
        .rdata_b(h3[7])
    );

    // fade and gradients
    always_comb begin
        logic [15:0]        t2;
        logic [15:0]        t3;
        logic signed [21:0] ps;
        logic [20:0]        fr;
        off_t               o0 [3];
        off_t               o1 [3];
        for (int ax = 0; ax < 3; ax++) begin
            s1_sq_next[ax]  = 32'(frac[ax]) * 32'(frac[ax]);
            t2              = 16'((33'(s1_sq_reg[ax]) + 33'd32768) >> 16);
            s2_t2t_next[ax] = 32'(t2) * 32'(s1_t_reg[ax]);
            ps = 22'sd655360 + $signed(22'(t2) * 22'd6) - $signed(22'(s1_t_reg[ax]) * 22'd15);
            s2_poly_next[ax] = ps[21] ? 20'd0 : ps[19:0];
            t3              = 16'((33'(s2_t2t_reg[ax]) + 33'd32768) >> 16);
            s3_fp_next[ax]  = 36'(t3) * 36'(s2_poly_reg[ax]);
            fr              = 21'((37'(s3_fp_reg[ax]) + 37'd32768) >> 16);
            s4_f_next[ax]   = (fr > 21'd65536) ? 17'd65536 : fr[16:0];
            o0[ax]          = off_t'({2'b00, s3_t_reg[ax]});
            o1[ax]          = o0[ax] - 18'sd65536;
        end
        for (int c = 0; c < 8; c++) begin
            s4_g_next[c] = lerp_t'(grad_q16(h3[c][3:0],
                                            c[0] ? o1[0] : o0[0],
                                            c[1] ? o1[1] : o0[1],
                                            c[2] ? o1[2] : o0[2]));
        end
    end

    // trilinear blend and output scaling
    always_comb begin
        logic signed [20:0] nsum;
        logic [19:0]        half;
        logic [29:0]        shs;
        for (int i = 0; i < 4; i++) begin
            s5_a_next[i] = s4_g_reg[2*i];
            s5_p_next[i] = (prod_t'(s4_g_reg[2*i+1]) - prod_t'(s4_g_reg[2*i]))
                           * prod_t'({1'b0, s4_f_reg[0]});
            s6_l_next[i] = lerp_fin(s5_a_reg[i], s5_p_reg[i]);
        end
        for (int j = 0; j < 2; j++) begin
            s7_a_next[j] = s6_l_reg[2*j];
            s7_p_next[j] = (prod_t'(s6_l_reg[2*j+1]) - prod_t'(s6_l_reg[2*j]))
                           * prod_t'({1'b0, s6_v_reg});
            s8_l_next[j] = lerp_fin(s7_a_reg[j], s7_p_reg[j]);
        end
        s9_p_next  = (prod_t'(s8_l_reg[1]) - prod_t'(s8_l_reg[0])) * prod_t'({1'b0, s8_w_reg});
        s10_n_next = lerp_fin(s9_a_reg, s9_p_reg);
        nsum = 21'(s10_n_reg) + 21'sd65537;
        half = nsum[20] ? 20'd0 : nsum[20:1];
        s11_nv_next   = (half > 20'd65536) ? 17'd65536 : half[16:0];
        s11_prod_next = 29'(s11_nv_next) * 29'(scale_reg);
        shs = (30'(s11_prod_reg) + 30'd32768) >> 16;
        out_sh_next = (shs > 30'd4095) ? 12'd4095 : shs[11:0];
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s1_yi_reg <= ipart[1];
            s1_zi_reg <= ipart[2];
            s1_t_reg  <= frac;
            s1_sq_reg <= s1_sq_next;
        end
        if (adv[2]) begin
            s2_zi_reg   <= s1_zi_reg;
            s2_t_reg    <= s1_t_reg;
            s2_t2t_reg  <= s2_t2t_next;
            s2_poly_reg <= s2_poly_next;
        end
        if (adv[3]) begin
            s3_t_reg  <= s2_t_reg;
            s3_fp_reg <= s3_fp_next;
        end
        if (adv[4]) begin
            s4_g_reg <= s4_g_next;
            s4_f_reg <= s4_f_next;
        end
        if (adv[5]) begin
            s5_a_reg <= s5_a_next;
            s5_p_reg <= s5_p_next;
            s5_v_reg <= s4_f_reg[1];
            s5_w_reg <= s4_f_reg[2];
        end
        if (adv[6]) begin
            s6_l_reg <= s6_l_next;
            s6_v_reg <= s5_v_reg;
            s6_w_reg <= s5_w_reg;
        end
        if (adv[7]) begin
            s7_a_reg <= s7_a_next;
            s7_p_reg <= s7_p_next;
            s7_w_reg <= s6_w_reg;
        end
        if (adv[8]) begin
            s8_l_reg <= s8_l_next;
            s8_w_reg <= s7_w_reg;
        end
        if (adv[9]) begin
            s9_a_reg <= s8_l_reg[0];
            s9_p_reg <= s9_p_next;
        end
        if (adv[10]) begin
            s10_n_reg <= s10_n_next;
        end
        if (adv[11]) begin
            s11_nv_reg   <= s11_nv_next;
            s11_prod_reg <= s11_prod_next;
        end
        if (adv[12]) begin
            out_nv_reg <= s11_nv_reg;
            out_sh_reg <= out_sh_next;
        end
    end

endmodule

// ----- src/pn3d_ram.sv -----
// generic ram, one write port and two registered read ports
module pn3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
